@@ design/msd_pkg.sv @@
// Shared constants, types and helpers for the multichannel switch debouncer.
package msd_pkg;

  // Channel count and hold counter width.
  localparam int CHANNELS   = 8;
  localparam int COUNT_BITS = 10;

  // Widths of the register and stream fields.
  localparam int FILTER_BITS = 10;
  localparam int LEVEL_BITS  = 8;
  localparam int WORD_BITS   = 8;
  localparam int OUT_BITS    = 2 * WORD_BITS;

  // Compare width that holds both the counter and the filter time.
  localparam int CMP_BITS = (COUNT_BITS > FILTER_BITS) ? COUNT_BITS : FILTER_BITS;

  // Reset value of the filter time register.
  localparam logic [FILTER_BITS-1:0] FILTER_RESET = FILTER_BITS'(100);

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // Per-item control broadcast to every lane.
  typedef struct packed {
    logic  step;
    kind_t kind;
  } lane_ctrl_t;

  // Fit a per-channel vector into an output field: low bits kept, missing ones zero.
  function automatic logic [WORD_BITS-1:0] to_word(input logic [CHANNELS-1:0] v);
    logic [WORD_BITS-1:0] w;
    w = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i < CHANNELS) begin
        w[i] = v[i % CHANNELS];
      end
    end
    return w;
  endfunction

endpackage

@@ design/multichannel_switch_debouncer.sv @@
// Top level: debounces all channels in parallel lanes, one word per cycle while s_tready is high.
// The result word goes into the output register, or first into the skid register while the output is stalled.
// Throughput: one word per cycle while the skid stage is empty; each lane updates in the cycle of acceptance.
// A skid stage lets one more word in while the output is stalled.
// Reset (rst, synchronous, active high): counters and timing clear, previous
// levels go high, the debounced word clears and filter_time returns to 100.
module multichannel_switch_debouncer (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write channel: filter_time.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msd_pkg::FILTER_BITS-1:0]    cfg_data,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [msd_pkg::LEVEL_BITS-1:0]     s_tdata,   // [7:0] levels
  input  logic                               s_tuser,   // [0] kind
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [msd_pkg::OUT_BITS-1:0]       m_tdata    // [7:0] stable_word, [15:8] accepted_mask
);

  logic [msd_pkg::FILTER_BITS-1:0] filter_time;
  msd_pkg::lane_ctrl_t             ctrl;
  logic [msd_pkg::CHANNELS-1:0]    stable_bits;
  logic [msd_pkg::CHANNELS-1:0]    accepted_bits;
  logic                            in_ready;

  // Filter time register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_time <= msd_pkg::FILTER_RESET;
    end else if (cfg_valid) begin
      filter_time <= cfg_data;
    end
  end

  // Broadcast the accepted word's control to every lane.
  assign s_tready  = in_ready;
  assign ctrl.step = s_tvalid & in_ready;
  assign ctrl.kind = msd_pkg::kind_t'(s_tuser);

  // One lane per channel; channels beyond the levels field see a low level.
  for (genvar n = 0; n < msd_pkg::CHANNELS; n++) begin : g_lane
    logic lane_level;
    if (n < msd_pkg::LEVEL_BITS) begin : g_pin
      assign lane_level = s_tdata[n];
    end else begin : g_none
      assign lane_level = 1'b0;
    end

    msd_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .level       (lane_level),
      .filter_time (filter_time),
      .stable_next (stable_bits[n]),
      .accepted    (accepted_bits[n])
    );
  end

  // Combine lane results and hold them for the output.
  msd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (ctrl.step),
    .stable_bits   (stable_bits),
    .accepted_bits (accepted_bits),
    .in_ready      (in_ready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_data      (m_tdata)
  );

endmodule

@@ design/msd_lane.sv @@
// One debounce lane: hold counter, timing flag, previous level and committed bit.
module msd_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  msd_pkg::lane_ctrl_t              ctrl,
  input  logic                             level,
  input  logic [msd_pkg::FILTER_BITS-1:0]  filter_time,
  output logic                             stable_next,
  output logic                             accepted
);

  logic [msd_pkg::COUNT_BITS-1:0] count;
  logic [msd_pkg::COUNT_BITS-1:0] count_next;
  logic                           timing;
  logic                           timing_next;
  logic                           prev_level;
  logic                           prev_level_next;
  logic                           stable;

  logic                           changed;
  logic [msd_pkg::COUNT_BITS-1:0] count_cleared;
  logic [msd_pkg::CMP_BITS-1:0]   count_ext;
  logic [msd_pkg::CMP_BITS-1:0]   cleared_ext;
  logic [msd_pkg::CMP_BITS-1:0]   filter_ext;

  // Bring counter and filter time to a common width for comparison.
  assign changed       = level != prev_level;
  assign count_cleared = changed ? '0 : count;
  assign count_ext     = msd_pkg::CMP_BITS'(count);
  assign cleared_ext   = msd_pkg::CMP_BITS'(count_cleared);
  assign filter_ext    = msd_pkg::CMP_BITS'(filter_time);

  // Next lane state for the current item.
  always_comb begin
    count_next      = count;
    timing_next     = timing;
    prev_level_next = prev_level;
    stable_next     = stable;
    accepted        = 1'b0;
    if (ctrl.step) begin
      unique case (ctrl.kind)
        msd_pkg::KIND_TICK: begin
          // Count up while timing, saturating at the filter time and the counter limit.
          if (timing && (count_ext < filter_ext) && (count != '1)) begin
            count_next = count + 1'b1;
          end
        end
        msd_pkg::KIND_SAMPLE: begin
          // A change restarts timing; a level commits once its count, cleared on a change, reaches the filter time.
          prev_level_next = level;
          if (cleared_ext >= filter_ext) begin
            count_next  = '0;
            timing_next = 1'b0;
            accepted    = 1'b1;
            stable_next = ~level;
          end else begin
            count_next  = count_cleared;
            timing_next = timing | changed;
          end
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Lane state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      timing     <= 1'b0;
      prev_level <= 1'b1;
      stable     <= 1'b0;
    end else begin
      count      <= count_next;
      timing     <= timing_next;
      prev_level <= prev_level_next;
      stable     <= stable_next;
    end
  end

endmodule

@@ design/msd_merge.sv @@
// Merges lane results into one result word and buffers it in an output register with skid.
module msd_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [msd_pkg::CHANNELS-1:0]        stable_bits,
  input  logic [msd_pkg::CHANNELS-1:0]        accepted_bits,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [msd_pkg::OUT_BITS-1:0]        out_data
);

  logic [msd_pkg::OUT_BITS-1:0] push_data;
  logic [msd_pkg::OUT_BITS-1:0] skid_data;
  logic                         skid_valid;
  logic                         drain;

  // Pack stable_word low, accepted_mask high.
  assign push_data = {msd_pkg::to_word(accepted_bits), msd_pkg::to_word(stable_bits)};

  // The skid stage catches one word while the output is stalled.
  assign in_ready = ~skid_valid;
  assign drain    = ~out_valid | out_ready;

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ tb/sv/multichannel_switch_debouncer_tb.sv @@
// Self-checking testbench for the multichannel switch debouncer, with a scoreboard and stream drivers.
`timescale 1ns / 100ps

module multichannel_switch_debouncer_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int IDLE_PERCENT  = 13;
  localparam int COUNT_MAX     = (1 << msd_pkg::COUNT_BITS) - 1;

  // One expected output word, split into its fields.
  typedef struct packed {
    logic [msd_pkg::WORD_BITS-1:0] stable_word;
    logic [msd_pkg::WORD_BITS-1:0] accepted_mask;
  } debounce_result_t;

  // Tracks debouncer state and checks each output word against the oldest expectation.
  class debounce_scoreboard;
    logic [msd_pkg::FILTER_BITS-1:0] filter_time;
    logic [msd_pkg::CHANNELS-1:0]    last_levels;
    logic [msd_pkg::CHANNELS-1:0]    timing;
    logic [msd_pkg::CHANNELS-1:0]    debounced;
    logic [msd_pkg::COUNT_BITS-1:0]  hold [msd_pkg::CHANNELS];
    debounce_result_t                expected_q [$];
    int                              fails;

    function new();
      filter_time = msd_pkg::FILTER_RESET;
      last_levels = '1;
      timing      = '0;
      debounced   = '0;
      fails       = 0;
      for (int n = 0; n < msd_pkg::CHANNELS; n++) hold[n] = '0;
    endfunction

    function void note_filter(logic [msd_pkg::FILTER_BITS-1:0] value);
      filter_time = value;
    endfunction

    // Update the channel state for one accepted input word and queue its result.
    function void note_word(msd_pkg::kind_t kind, logic [msd_pkg::LEVEL_BITS-1:0] levels);
      logic [msd_pkg::CHANNELS-1:0] accepted;
      debounce_result_t             res;
      logic                         lvl;
      accepted = '0;
      if (kind == msd_pkg::KIND_TICK) begin
        for (int n = 0; n < msd_pkg::CHANNELS; n++) begin
          if (timing[n] && int'(hold[n]) < int'(filter_time) &&
              int'(hold[n]) < COUNT_MAX) begin
            hold[n] = hold[n] + 1'b1;
          end
        end
      end else begin
        for (int n = 0; n < msd_pkg::CHANNELS; n++) begin
          lvl = (n < msd_pkg::LEVEL_BITS) ? levels[n] : 1'b0;
          // A level change restarts the hold time.
          if (lvl != last_levels[n]) begin
            hold[n]   = '0;
            timing[n] = 1'b1;
          end
          // A level that has been stable long enough is committed.
          if (int'(hold[n]) >= int'(filter_time)) begin
            timing[n]    = 1'b0;
            hold[n]      = '0;
            accepted[n]  = 1'b1;
            debounced[n] = ~lvl;
          end
          last_levels[n] = lvl;
        end
      end
      res.stable_word   = msd_pkg::WORD_BITS'(debounced);
      res.accepted_mask = msd_pkg::WORD_BITS'(accepted);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [msd_pkg::OUT_BITS-1:0] data);
      debounce_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output word %h", data);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (data[msd_pkg::WORD_BITS-1:0] !== want.stable_word) begin
        $error("stable_word: expected %h, actual %h", want.stable_word,
               data[msd_pkg::WORD_BITS-1:0]);
        fails++;
      end
      if (data[msd_pkg::OUT_BITS-1:msd_pkg::WORD_BITS] !== want.accepted_mask) begin
        $error("accepted_mask: expected %h, actual %h", want.accepted_mask,
               data[msd_pkg::OUT_BITS-1:msd_pkg::WORD_BITS]);
        fails++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [msd_pkg::FILTER_BITS-1:0] cfg_data  = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [msd_pkg::LEVEL_BITS-1:0]  s_tdata   = '0;
  logic                            s_tuser   = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [msd_pkg::OUT_BITS-1:0]    m_tdata;

  debounce_scoreboard sb = new();
  logic               calm = 1'b0;
  int                 cycles = 0;

  multichannel_switch_debouncer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output stall: random back-pressure except during the calm phase.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watch all three channels at each edge; input and config are noted before the output check.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_filter(cfg_data);
      if (s_tvalid && s_tready) sb.note_word(msd_pkg::kind_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multichannel_switch_debouncer_tb NOT OK");
      $finish;
    end
  end

  // Send one input word, with random idle cycles ahead of it outside the calm phase.
  task automatic push_word(input msd_pkg::kind_t kind,
                           input logic [msd_pkg::LEVEL_BITS-1:0] levels);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= levels;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Write filter_time once the block has gone quiet.
  task automatic set_filter(input logic [msd_pkg::FILTER_BITS-1:0] value);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: ticks and samples whose levels bounce a few bits at a time or jump anew.
  task automatic run_phase(input int count, input int tick_pct, input bit pause_mid);
    logic [msd_pkg::LEVEL_BITS-1:0] cur_levels;
    logic [msd_pkg::LEVEL_BITS-1:0] flips;
    cur_levels = msd_pkg::LEVEL_BITS'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) drain_results();
      if ($urandom_range(0, 99) < tick_pct) begin
        push_word(msd_pkg::KIND_TICK, msd_pkg::LEVEL_BITS'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          cur_levels = msd_pkg::LEVEL_BITS'($urandom_range(0, 255));
        end else begin
          flips = '0;
          for (int b = 0; b < msd_pkg::LEVEL_BITS; b++) begin
            flips[b] = ($urandom_range(0, 7) == 0);
          end
          cur_levels = cur_levels ^ flips;
        end
        push_word(msd_pkg::KIND_SAMPLE, cur_levels);
      end
    end
  endtask

  initial begin
    int filter;
    int count;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: all-high levels match, all-low levels start timing at the reset filter.
    push_word(msd_pkg::KIND_TICK, 8'h00);
    push_word(msd_pkg::KIND_SAMPLE, 8'hFF);
    push_word(msd_pkg::KIND_SAMPLE, 8'h00);
    push_word(msd_pkg::KIND_TICK, 8'hFF);
    push_word(msd_pkg::KIND_SAMPLE, 8'h00);

    // Zero filter time commits every channel on every sample, changed or not.
    set_filter('0);
    push_word(msd_pkg::KIND_SAMPLE, 8'hA5);
    push_word(msd_pkg::KIND_TICK, 8'h3C);
    push_word(msd_pkg::KIND_SAMPLE, 8'h5A);
    push_word(msd_pkg::KIND_SAMPLE, 8'h5A);

    // Filter of one: a tick is needed, and counts saturate at the filter time.
    set_filter(10'd1);
    push_word(msd_pkg::KIND_SAMPLE, 8'hFF);
    push_word(msd_pkg::KIND_SAMPLE, 8'hFF);
    push_word(msd_pkg::KIND_TICK, 8'h00);
    push_word(msd_pkg::KIND_SAMPLE, 8'hFF);
    push_word(msd_pkg::KIND_SAMPLE, 8'h00);
    push_word(msd_pkg::KIND_TICK, 8'h00);
    push_word(msd_pkg::KIND_TICK, 8'h00);
    push_word(msd_pkg::KIND_SAMPLE, 8'h0F);
    push_word(msd_pkg::KIND_TICK, 8'h00);
    push_word(msd_pkg::KIND_SAMPLE, 8'h0F);

    // Largest filter time.
    set_filter('1);
    push_word(msd_pkg::KIND_SAMPLE, 8'hF0);
    push_word(msd_pkg::KIND_TICK, 8'hAA);

    // Random phases over several filter settings.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: filter = 80;
        1: filter = 1023;
        2: filter = 0;
        3: filter = 100;
        4: filter = 2;
        default: begin
          filter = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) :
                                                 $urandom_range(1, 6);
        end
      endcase
      set_filter(msd_pkg::FILTER_BITS'(filter));
      calm = (p == 4);
      count = (filter >= 20) ? (((filter > 200) ? 200 : filter) + 60) : 45;
      run_phase(count, (filter >= 20) ? 94 : 50, p == 3);
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("multichannel_switch_debouncer_tb OK");
    end else begin
      $display("multichannel_switch_debouncer_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ multichannel_switch_debouncer.f @@
design/msd_pkg.sv
design/msd_lane.sv
design/msd_merge.sv
design/multichannel_switch_debouncer.sv
tb/sv/multichannel_switch_debouncer_tb.sv
